@@ hdl/mcif_pkg.sv @@
// ---------------------------------------------------------------------------
// Multichannel IIR filter package
// Shared command codes, state encodings and front-to-back queue entry type.
// ---------------------------------------------------------------------------
package mcif_pkg;

   typedef enum logic [1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_FF_TAP = 2'd1,
      CMD_FB_TAP = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef enum logic [0:0] {
      REG_FF_TAPS_USED = 1'd0,
      REG_FB_TAPS_USED = 1'd1
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FF,
      ST_FB,
      ST_ROUND,
      ST_SHIFT,
      ST_CLEAR
   } state_type;

   localparam int CMD_BITS   = 2;
   localparam int CHAN_BITS  = 3;
   localparam int TAP_BITS   = 4;
   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 24;
   localparam int CSR_DATA_W = 5;

   // One classified transaction as it travels from front to back.
   typedef struct packed {
      cmd_type                   cmd;
      logic [CHAN_BITS-1:0]      channel;
      logic [TAP_BITS-1:0]       tap_index;
      logic signed [SAMPLE_W-1:0] sample_value;
      logic signed [COEF_W-1:0]  coef_value;
   } entry_type;

endpackage

@@ hdl/mcif_if.sv @@
// ---------------------------------------------------------------------------
// Multichannel IIR filter channel interfaces
// Valid/ready request and response channels with source and sink modports.
// ---------------------------------------------------------------------------
interface mcif_req_if;
   logic                                      valid;
   logic                                      ready;
   logic [mcif_pkg::CMD_BITS-1:0]             command;
   logic [mcif_pkg::CHAN_BITS-1:0]            channel;
   logic [mcif_pkg::TAP_BITS-1:0]             tap_index;
   logic signed [mcif_pkg::SAMPLE_W-1:0]      sample_value;
   logic signed [mcif_pkg::COEF_W-1:0]        coef_value;
   modport source (output valid, command, channel, tap_index, sample_value,
                   coef_value, input ready);
   modport sink (input valid, command, channel, tap_index, sample_value,
                 coef_value, output ready);
endinterface

interface mcif_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic [mcif_pkg::CHAN_BITS-1:0]            channel_res;
   logic signed [mcif_pkg::SAMPLE_W-1:0]      filtered_value;
   logic                                      saturated;
   modport source (output valid, channel_res, filtered_value, saturated,
                   input ready);
   modport sink (input valid, channel_res, filtered_value, saturated,
                 output ready);
endinterface

@@ hdl/multichannel_iir_filter_top.sv @@
// ---------------------------------------------------------------------------
// Multichannel IIR filter top level
// Direct form I filter shared over interleaved channels.
// ---------------------------------------------------------------------------
// Channel | Direction | Contents
// req     | in        | command, channel, tap_index, sample_value, coef_value
// rsp     | out       | channel_res, filtered_value, saturated
// csr     | in        | tap counts, write only
// A sample holds the back end through its feedforward, feedback, rounding and
// history shift steps; its result is valid once rounding is done, and the
// history shift follows. Reset is synchronous; histories read as zero
// through per-channel valid bits. A two-entry queue lets the front accept
// while the back works; a stalled result holds back the next sample.
module multichannel_iir_filter_top #(
   parameter int CHANNELS = 8,
   parameter int FF_TAPS  = 16,
   parameter int FB_TAPS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   mcif_req_if.sink    req,
   mcif_rsp_if.source  rsp,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [4:0]  csr_wdata
);
   logic [4:0] ff_used_ff, fb_used_ff;
   mcif_pkg::entry_type q_entry;
   logic q_valid, q_pop;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ff_used_ff <= 5'd1;
         fb_used_ff <= 5'd0;
      end else if (csr_we) begin
         case (mcif_pkg::reg_index_type'(csr_index))
            mcif_pkg::REG_FF_TAPS_USED: ff_used_ff <= csr_wdata;
            mcif_pkg::REG_FB_TAPS_USED: fb_used_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   mcif_front #(.CHANNELS(CHANNELS), .FF_TAPS(FF_TAPS), .FB_TAPS(FB_TAPS)) u_front (
      .clock, .reset, .req, .q_entry, .q_valid, .q_pop);

   mcif_back #(.CHANNELS(CHANNELS), .FF_TAPS(FF_TAPS), .FB_TAPS(FB_TAPS)) u_back (
      .clock, .reset, .ff_used(ff_used_ff), .fb_used(fb_used_ff),
      .q_entry, .q_valid, .q_pop, .rsp);
endmodule

@@ hdl/mcif_ram.sv @@
// ---------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ---------------------------------------------------------------------------
module mcif_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hdl/mcif_front.sv @@
// ---------------------------------------------------------------------------
// Multichannel IIR filter front end
// Accepts request transactions, drops ones that do nothing, queues the rest.
// ---------------------------------------------------------------------------
module mcif_front #(
   parameter int CHANNELS = 8,
   parameter int FF_TAPS  = 16,
   parameter int FB_TAPS  = 16
) (
   input  logic                clock,
   input  logic                reset,
   mcif_req_if.sink            req,
   output mcif_pkg::entry_type q_entry,
   output logic                q_valid,
   input  logic                q_pop
);
   localparam int QD = 2;

   mcif_pkg::entry_type q_mem_ff [QD];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, keep;
   mcif_pkg::entry_type new_entry;

   assign req.ready = (count_ff != 2'd2);

   // Classify: samples on out-of-range channels and out-of-range tap writes are discarded here.
   always_comb begin
      new_entry.cmd          = mcif_pkg::cmd_type'(req.command);
      new_entry.channel      = req.channel;
      new_entry.tap_index    = req.tap_index;
      new_entry.sample_value = req.sample_value;
      new_entry.coef_value   = req.coef_value;
      case (new_entry.cmd)
         mcif_pkg::CMD_SAMPLE: keep = ({1'b0, req.channel} < (CHANNELS));
         mcif_pkg::CMD_FF_TAP: keep = ({1'b0, req.tap_index} < (FF_TAPS));
         mcif_pkg::CMD_FB_TAP: keep = ({1'b0, req.tap_index} < (FB_TAPS));
         default:              keep = 1'b1;
      endcase
   end

   assign push    = req.valid && req.ready && keep;
   assign q_valid = (count_ff != 2'd0);
   assign q_entry = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= new_entry;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> !push) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("queue underflow");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !q_pop |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count did not advance");
`endif
endmodule

@@ hdl/mcif_back.sv @@
// ---------------------------------------------------------------------------
// Multichannel IIR filter back end
// Shared multiply-accumulate sequencer over per-channel history memories.
// ---------------------------------------------------------------------------
module mcif_back #(
   parameter int CHANNELS = 8,
   parameter int FF_TAPS  = 16,
   parameter int FB_TAPS  = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [4:0]          ff_used,
   input  logic [4:0]          fb_used,
   input  mcif_pkg::entry_type q_entry,
   input  logic                q_valid,
   output logic                q_pop,
   mcif_rsp_if.source          rsp
);
   localparam int SW   = mcif_pkg::SAMPLE_W;
   localparam int CW   = mcif_pkg::COEF_W;
   localparam int FRAC = CW - 4;
   localparam int CB   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int XD   = (FF_TAPS > 1) ? FF_TAPS - 1 : 1;
   localparam int XB   = (XD > 1) ? $clog2(XD) : 1;
   localparam int YB   = (FB_TAPS > 1) ? $clog2(FB_TAPS) : 1;
   localparam int FB   = (FF_TAPS > 1) ? $clog2(FF_TAPS) : 1;
   localparam int XDEP = CHANNELS * (1 << XB);
   localparam int YDEP = CHANNELS * (1 << YB);
   localparam int XA   = $clog2(XDEP);
   localparam int YA   = $clog2(YDEP);
   localparam int KB   = 9;
   localparam int AW   = 64;

   // Coefficient tables, small and each read at one sequencer address.
   logic signed [CW-1:0] ff_coef_ff [FF_TAPS];
   logic signed [CW-1:0] fb_coef_ff [FB_TAPS];

   mcif_pkg::state_type state_ff, state_in;
   mcif_pkg::entry_type cur_ff;
   logic [KB-1:0]        k_ff, k_in;
   logic                 ph_ff, ph_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [SW+CW-1:0] prod_ff;
   logic                 prod_v_ff;
   logic signed [SW-1:0] y_ff;
   logic                 out_v_ff;
   logic [mcif_pkg::CHAN_BITS-1:0] out_ch_ff;
   logic signed [SW-1:0] out_y_ff;
   logic                 out_sat_ff;
   logic                 valid_x_ff [CHANNELS];
   logic                 valid_y_ff [CHANNELS];

   logic [KB-1:0] nff, nfb;
   logic          x_we, y_we;
   logic [XA-1:0] x_wa, x_ra;
   logic [YA-1:0] y_wa, y_ra;
   logic [SW-1:0] x_wd, y_wd, x_rd, y_rd;
   logic [CB-1:0] ch;
   logic signed [SW-1:0] mul_s;
   logic signed [CW-1:0] mul_c;
   logic          mul_go;
   logic signed [AW-1:0] rounded;
   logic signed [SW-1:0] y_sat;
   logic          y_clip;

   // Per-channel history memories.
   mcif_ram #(.WIDTH(SW), .DEPTH(XDEP)) u_xh (
      .clock, .wr_en(x_we), .wr_addr(x_wa), .wr_data(x_wd),
      .rd_addr(x_ra), .rd_data(x_rd));
   mcif_ram #(.WIDTH(SW), .DEPTH(YDEP)) u_yh (
      .clock, .wr_en(y_we), .wr_addr(y_wa), .wr_data(y_wd),
      .rd_addr(y_ra), .rd_data(y_rd));

   assign ch  = cur_ff.channel[CB-1:0];
   assign nff = ({4'd0, ff_used} > KB'(FF_TAPS)) ? KB'(FF_TAPS) : {4'd0, ff_used};
   assign nfb = ({4'd0, fb_used} > KB'(FB_TAPS)) ? KB'(FB_TAPS) : {4'd0, fb_used};

   // Round half up, then saturate.
   assign rounded = (acc_ff + (AW'(1) <<< (FRAC - 1))) >>> FRAC;
   always_comb begin
      y_clip = 1'b1;
      if (rounded > AW'((1 <<< (SW - 1)) - 1)) begin
         y_sat = {1'b0, {(SW-1){1'b1}}};
      end else if (rounded < -AW'(1 <<< (SW - 1))) begin
         y_sat = {1'b1, {(SW-1){1'b0}}};
      end else begin
         y_sat  = rounded[SW-1:0];
         y_clip = 1'b0;
      end
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mcif_pkg::ST_IDLE: begin
            if (q_valid) begin
               case (q_entry.cmd)
                  mcif_pkg::CMD_SAMPLE:
                     if (!out_v_ff || rsp.ready) state_in = mcif_pkg::ST_FF;
                  mcif_pkg::CMD_CLEAR: state_in = mcif_pkg::ST_CLEAR;
                  default: state_in = mcif_pkg::ST_IDLE;
               endcase
            end
         end
         mcif_pkg::ST_FF:    if (k_ff >= nff) state_in = mcif_pkg::ST_FB;
         mcif_pkg::ST_FB:    if (k_ff >= nfb + KB'(2)) state_in = mcif_pkg::ST_ROUND;
         mcif_pkg::ST_ROUND: state_in = mcif_pkg::ST_SHIFT;
         mcif_pkg::ST_SHIFT: begin
            if (k_ff == KB'(XD) && k_ff >= KB'(FB_TAPS) && ph_ff)
               state_in = mcif_pkg::ST_IDLE;
            else if (k_ff >= KB'(XD) && k_ff >= KB'(FB_TAPS) && ph_ff)
               state_in = mcif_pkg::ST_IDLE;
         end
         mcif_pkg::ST_CLEAR: state_in = mcif_pkg::ST_IDLE;
         default:            state_in = mcif_pkg::ST_IDLE;
      endcase
   end

   // Output and datapath control.
   always_comb begin
      q_pop  = 1'b0;
      k_in   = k_ff;
      ph_in  = ph_ff;
      acc_in = acc_ff;
      x_we = 1'b0; y_we = 1'b0;
      x_wa = '0; y_wa = '0; x_wd = '0; y_wd = '0;
      x_ra = {ch, XB'(0)};
      y_ra = {ch, YB'(0)};
      mul_go = 1'b0;
      mul_s = '0;
      mul_c = '0;
      if (prod_v_ff) acc_in = acc_ff + AW'(prod_ff);
      case (state_ff)
         mcif_pkg::ST_IDLE: begin
            k_in = '0;
            ph_in = 1'b0;
            acc_in = '0;
            if (q_valid) begin
               case (q_entry.cmd)
                  mcif_pkg::CMD_SAMPLE: q_pop = !out_v_ff || rsp.ready;
                  default:              q_pop = 1'b1;
               endcase
            end
         end
         mcif_pkg::ST_FF: begin
            // Step k addresses entry k; reads are registered; tap 0 is the new sample.
            x_ra = {ch, XB'(k_ff)};
            if (k_ff == '0) begin
               if (nff != '0) begin
                  mul_go = 1'b1; mul_s = cur_ff.sample_value; mul_c = ff_coef_ff[0];
               end
            end else if (k_ff < nff) begin
               mul_go = 1'b1;
               mul_s  = valid_x_ff[ch] ? x_rd : '0;
               mul_c  = ff_coef_ff[FB'(k_ff)];
            end
            k_in = (k_ff >= nff) ? '0 : k_ff + KB'(1);
         end
         mcif_pkg::ST_FB: begin
            y_ra = {ch, YB'(k_ff)};
            if (k_ff >= KB'(1) && k_ff <= nfb) begin
               mul_go = 1'b1;
               mul_s  = valid_y_ff[ch] ? y_rd : '0;
               mul_c  = fb_coef_ff[YB'(k_ff - KB'(1))];
            end
            k_in = k_ff + KB'(1);
         end
         mcif_pkg::ST_ROUND: begin
            k_in = '0;
            ph_in = 1'b0;
         end
         mcif_pkg::ST_SHIFT: begin
            // Shift newest-first histories one entry per read-then-write step, from the end.
            if (!ph_ff) begin
               x_ra  = {ch, XB'(XD - 2 - int'(k_ff))};
               y_ra  = {ch, YB'(FB_TAPS - 2 - int'(k_ff))};
               ph_in = 1'b1;
            end else begin
               ph_in = 1'b0;
               k_in  = k_ff + KB'(1);
               if (FF_TAPS > 1 && k_ff < KB'(XD)) begin
                  x_we = 1'b1;
                  x_wa = {ch, XB'(XD - 1 - int'(k_ff))};
                  x_wd = (k_ff == KB'(XD - 1)) ? cur_ff.sample_value
                         : (valid_x_ff[ch] ? x_rd : '0);
               end
               if (k_ff < KB'(FB_TAPS)) begin
                  y_we = 1'b1;
                  y_wa = {ch, YB'(FB_TAPS - 1 - int'(k_ff))};
                  y_wd = (k_ff == KB'(FB_TAPS - 1)) ? y_ff
                         : (valid_y_ff[ch] ? y_rd : '0);
               end
            end
         end
         default: ;
      endcase
   end

   // Registers.
   always_ff @(posedge clock) begin
      prod_ff <= mul_s * mul_c;
      if (state_ff == mcif_pkg::ST_IDLE && q_pop) cur_ff <= q_entry;
      if (state_ff == mcif_pkg::ST_ROUND) y_ff <= y_sat;
      acc_ff <= acc_in;
      k_ff   <= k_in;
      ph_ff  <= ph_in;
      if (state_ff == mcif_pkg::ST_IDLE && q_pop &&
          q_entry.cmd == mcif_pkg::CMD_FF_TAP)
         ff_coef_ff[FB'(q_entry.tap_index)] <= q_entry.coef_value;
      if (state_ff == mcif_pkg::ST_IDLE && q_pop &&
          q_entry.cmd == mcif_pkg::CMD_FB_TAP)
         fb_coef_ff[YB'(q_entry.tap_index)] <= q_entry.coef_value;
      if (state_ff == mcif_pkg::ST_ROUND) begin
         out_ch_ff  <= cur_ff.channel;
         out_y_ff   <= y_sat;
         out_sat_ff <= y_clip;
      end
      if (reset) begin
         state_ff      <= mcif_pkg::ST_IDLE;
         prod_v_ff     <= 1'b0;
         out_v_ff      <= 1'b0;
         for (int i = 0; i < FF_TAPS; i++) ff_coef_ff[i] <= '0;
         for (int i = 0; i < FB_TAPS; i++) fb_coef_ff[i] <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            valid_x_ff[i] <= 1'b0;
            valid_y_ff[i] <= 1'b0;
         end
      end else begin
         state_ff  <= state_in;
         prod_v_ff <= mul_go;
         if (state_ff == mcif_pkg::ST_ROUND) out_v_ff <= 1'b1;
         else if (rsp.ready) out_v_ff <= 1'b0;
         // A channel history reads as zero until its first full shift pass.
         if (state_ff == mcif_pkg::ST_SHIFT && state_in == mcif_pkg::ST_IDLE) begin
            valid_x_ff[ch] <= 1'b1;
            valid_y_ff[ch] <= 1'b1;
         end
         if (state_ff == mcif_pkg::ST_CLEAR) begin
            for (int i = 0; i < CHANNELS; i++) begin
               valid_x_ff[i] <= 1'b0;
               valid_y_ff[i] <= 1'b0;
            end
         end
      end
   end

   // Response channel.
   assign rsp.valid          = out_v_ff;
   assign rsp.channel_res    = out_ch_ff;
   assign rsp.filtered_value = out_y_ff;
   assign rsp.saturated      = out_sat_ff;

`ifndef SYNTHESIS
   a_sat_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.saturated |->
         (rsp.filtered_value == {1'b0, {(SW-1){1'b1}}}) ||
         (rsp.filtered_value == {1'b1, {(SW-1){1'b0}}}))
      else $error("saturated result is not a range limit");
   a_round_loads: assert property (@(posedge clock) disable iff (reset)
      state_ff == mcif_pkg::ST_ROUND |=> out_v_ff)
      else $error("result not loaded after rounding");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !rsp.ready |=> out_v_ff && $stable(out_y_ff))
      else $error("result lost while stalled");
`endif
endmodule

@@ dv/mcif_tb_if.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Multichannel IIR filter testbench interfaces
// The testbench reuses the design's channel interfaces; this file holds the
// scoreboard class that predicts and checks filtered samples.
// ---------------------------------------------------------------------------
class iir_scoreboard;
   // Coefficients, tap counts and per-channel histories, newest first.
   logic signed [23:0] ff_coef[16];
   logic signed [23:0] fb_coef[16];
   logic signed [15:0] x_hist[8][15];
   logic signed [15:0] y_hist[8][16];
   int unsigned        ff_used;
   int unsigned        fb_used;
   logic [19:0]        pending_q[$];
   int                 error_count;

   function new();
      ff_used = 1;
      fb_used = 0;
      error_count = 0;
      foreach (ff_coef[i]) ff_coef[i] = '0;
      foreach (fb_coef[i]) fb_coef[i] = '0;
      clear_history();
   endfunction

   function void clear_history();
      foreach (x_hist[c, k]) x_hist[c][k] = '0;
      foreach (y_hist[c, k]) y_hist[c][k] = '0;
   endfunction

   function void write_count(bit idx, logic [4:0] value);
      if (idx == mcif_pkg::REG_FF_TAPS_USED) ff_used = value;
      else fb_used = value;
   endfunction

   // Notes one accepted request transaction and predicts its result.
   function void note_request(logic [1:0] cmd, logic [2:0] ch, logic [3:0] tap,
                              logic signed [15:0] x, logic signed [23:0] coef);
      longint      acc;
      longint      y;
      int unsigned nff;
      int unsigned nfb;
      bit          sat;
      case (cmd)
         mcif_pkg::CMD_FF_TAP: ff_coef[tap] = coef;
         mcif_pkg::CMD_FB_TAP: fb_coef[tap] = coef;
         mcif_pkg::CMD_CLEAR: clear_history();
         default: begin
            nff = (ff_used > 16) ? 16 : ff_used;
            nfb = (fb_used > 16) ? 16 : fb_used;
            acc = 0;
            for (int k = 0; k < nff; k++)
               acc += longint'(ff_coef[k]) * longint'((k == 0) ? x : x_hist[ch][k-1]);
            for (int k = 0; k < nfb; k++)
               acc += longint'(fb_coef[k]) * longint'(y_hist[ch][k]);
            acc += longint'(1) <<< 19;
            y = acc >>> 20;
            sat = 0;
            if (y > 32767) begin
               y = 32767;
               sat = 1;
            end else if (y < -32768) begin
               y = -32768;
               sat = 1;
            end
            for (int k = 14; k > 0; k--) x_hist[ch][k] = x_hist[ch][k-1];
            x_hist[ch][0] = x;
            for (int k = 15; k > 0; k--) y_hist[ch][k] = y_hist[ch][k-1];
            y_hist[ch][0] = y[15:0];
            pending_q.push_back({ch, y[15:0], sat});
         end
      endcase
   endfunction

   // Checks one accepted response transaction against the oldest prediction.
   function void check_response(logic [2:0] ch, logic [15:0] y, logic sat);
      logic [19:0] exp_r;
      if (pending_q.size() == 0) begin
         $display("%0t: unexpected response ch=%0d y=%0d sat=%0b", $time, ch,
                  $signed(y), sat);
         error_count++;
         return;
      end
      exp_r = pending_q.pop_front();
      if (exp_r[19:17] !== ch) begin
         $display("%0t: channel expected %0d actual %0d", $time, exp_r[19:17], ch);
         error_count++;
      end
      if (exp_r[16:1] !== y) begin
         $display("%0t: value expected %0d actual %0d", $time,
                  $signed(exp_r[16:1]), $signed(y));
         error_count++;
      end
      if (exp_r[0] !== sat) begin
         $display("%0t: saturated expected %0b actual %0b", $time, exp_r[0], sat);
         error_count++;
      end
   endfunction
endclass

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Multichannel IIR filter testbench
// Drives coefficient, sample and clear transactions under random gaps and
// stalls, and checks every filtered sample against a cycle-free predictor.
// ---------------------------------------------------------------------------
module tb_top;
   logic clock;
   logic reset;
   logic csr_we;
   logic csr_index;
   logic [4:0] csr_wdata;
   bit   hold_off;

   mcif_req_if req ();
   mcif_rsp_if rsp ();

   iir_scoreboard filter_sb = new();

   multichannel_iir_filter_top uut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Clock with a 4 ns period.
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = 1'b0;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.command = '0;
      req.channel = '0;
      req.tap_index = '0;
      req.sample_value = '0;
      req.coef_value = '0;
      rsp.ready = 1'b0;
   end

   function automatic int gap_length();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      return $urandom_range(0, 3);
   endfunction

   // Offers one request transaction and waits until it is accepted.
   // Valid stays high when the next transaction follows with no gap.
   task automatic send_request(mcif_pkg::cmd_type cmd, logic [2:0] ch,
                               logic [3:0] tap, logic [15:0] x, logic [23:0] coef);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.command <= cmd;
      req.channel <= ch;
      req.tap_index <= tap;
      req.sample_value <= x;
      req.coef_value <= coef;
      do @(posedge clock); while (!req.ready);
      filter_sb.note_request(cmd, ch, tap, x, coef);
   endtask

   task automatic write_count(mcif_pkg::reg_index_type idx, logic [4:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      filter_sb.write_count(idx, value);
   endtask

   // Waits for every predicted result and then for the block to go idle.
   task automatic drain();
      req.valid <= 1'b0;
      while (filter_sb.pending_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic random_taps(int scale);
      for (int k = 0; k < 16; k++) begin
         send_request(mcif_pkg::CMD_FF_TAP, 3'($urandom), 4'(k), 16'($urandom),
                      24'($signed(24'($urandom)) >>> scale));
         send_request(mcif_pkg::CMD_FB_TAP, 3'($urandom), 4'(k), 16'($urandom),
                      24'($signed(24'($urandom)) >>> (scale + 3)));
      end
   endtask

   task automatic random_samples(int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 90)
            send_request(mcif_pkg::CMD_SAMPLE, 3'($urandom), 4'($urandom),
                         16'($urandom), 24'($urandom));
         else if (pick < 94)
            send_request(mcif_pkg::CMD_FF_TAP, 3'($urandom), 4'($urandom),
                         16'($urandom), 24'($urandom));
         else if (pick < 98)
            send_request(mcif_pkg::CMD_FB_TAP, 3'($urandom), 4'($urandom),
                         16'($urandom), 24'($signed(24'($urandom)) >>> 3));
         else
            send_request(mcif_pkg::CMD_CLEAR, 3'($urandom), 4'($urandom),
                         16'($urandom), 24'($urandom));
      end
   endtask

   // Check every accepted response transaction.
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready)
         filter_sb.check_response(rsp.channel_res, rsp.filtered_value, rsp.saturated);
   end

   // Response side: random stalls, with one long hold-off on request.
   initial begin
      int stall;
      bit hold_taken;
      hold_taken = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_off && !hold_taken) begin
            hold_taken = 1'b1;
            rsp.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         stall = gap_length();
         rsp.ready <= (stall == 0);
         repeat (stall > 0 ? stall : 1) @(posedge clock);
         rsp.ready <= 1'b1;
         @(posedge clock);
      end
   end

   // Main sequence: directed cases, then random phases at several settings.
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Zero gain at reset settings, then an identity filter; sample extremes on several channels.
      send_request(mcif_pkg::CMD_SAMPLE, 3'd0, 4'd0, 16'h7FFF, 24'h0);
      send_request(mcif_pkg::CMD_FF_TAP, 3'd0, 4'd0, 16'h0, 24'h100000);
      send_request(mcif_pkg::CMD_SAMPLE, 3'd1, 4'd15, 16'h7FFF, 24'hFFFFFF);
      send_request(mcif_pkg::CMD_SAMPLE, 3'd7, 4'd0, 16'h8000, 24'h0);
      send_request(mcif_pkg::CMD_SAMPLE, 3'd2, 4'd0, 16'hFFFF, 24'h0);
      // Largest gains saturate both ways.
      send_request(mcif_pkg::CMD_FF_TAP, 3'd0, 4'd0, 16'h0, 24'h7FFFFF);
      send_request(mcif_pkg::CMD_SAMPLE, 3'd3, 4'd0, 16'h7FFF, 24'h0);
      send_request(mcif_pkg::CMD_SAMPLE, 3'd4, 4'd0, 16'h8000, 24'h0);
      send_request(mcif_pkg::CMD_FF_TAP, 3'd0, 4'd0, 16'h0, 24'h800000);
      send_request(mcif_pkg::CMD_SAMPLE, 3'd5, 4'd0, 16'h8000, 24'h0);
      send_request(mcif_pkg::CMD_SAMPLE, 3'd6, 4'd0, 16'h7FFF, 24'h0);
      // Half-LSB gain exercises rounding ties.
      send_request(mcif_pkg::CMD_FF_TAP, 3'd0, 4'd0, 16'h0, 24'h080000);
      send_request(mcif_pkg::CMD_SAMPLE, 3'd0, 4'd0, 16'h0001, 24'h0);
      send_request(mcif_pkg::CMD_SAMPLE, 3'd0, 4'd0, 16'hFFFF, 24'h0);
      send_request(mcif_pkg::CMD_FF_TAP, 3'd0, 4'd15, 16'h0, 24'h123456);
      send_request(mcif_pkg::CMD_FB_TAP, 3'd0, 4'd15, 16'h0, 24'hF00000);
      send_request(mcif_pkg::CMD_CLEAR, 3'd7, 4'd15, 16'hFFFF, 24'hFFFFFF);
      send_request(mcif_pkg::CMD_SAMPLE, 3'd0, 4'd0, 16'h4000, 24'h0);
      drain();

      // No feedforward taps; history keeps shifting.
      write_count(mcif_pkg::REG_FF_TAPS_USED, 5'd0);
      write_count(mcif_pkg::REG_FB_TAPS_USED, 5'd0);
      send_request(mcif_pkg::CMD_SAMPLE, 3'd1, 4'd0, 16'h1234, 24'h0);
      send_request(mcif_pkg::CMD_SAMPLE, 3'd1, 4'd0, 16'h5678, 24'h0);
      drain();

      // Counts above the table size, then full use, then mid values.
      write_count(mcif_pkg::REG_FF_TAPS_USED, 5'd31);
      write_count(mcif_pkg::REG_FB_TAPS_USED, 5'd31);
      random_taps(4);
      random_samples(200);
      drain();
      write_count(mcif_pkg::REG_FF_TAPS_USED, 5'd16);
      write_count(mcif_pkg::REG_FB_TAPS_USED, 5'd16);
      random_taps(2);
      hold_off = 1'b1;
      random_samples(200);
      drain();
      write_count(mcif_pkg::REG_FF_TAPS_USED, 5'd5);
      write_count(mcif_pkg::REG_FB_TAPS_USED, 5'd2);
      random_taps(1);
      random_samples(250);
      drain();
      write_count(mcif_pkg::REG_FF_TAPS_USED, 5'($urandom_range(0, 17)));
      write_count(mcif_pkg::REG_FB_TAPS_USED, 5'($urandom_range(0, 17)));
      random_samples(200);
      drain();

      if (filter_sb.error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

   // Run limit.
   initial begin
      #4000000;
      $display("tb_top: errors");
      $finish;
   end
endmodule
